// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the runway scheduler RTL.
// Expects signals named clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RPRQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rprq assertion failed");

// Next-cycle implication, checked out of reset.
`define RPRQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rprq assertion failed");

`endif

// ===== hdl/rprq_pkg.sv =====
// Shared types and constants for the runway priority queue scheduler.
// No dependencies; imported by the controller, datapath and top level.
package rprq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int TIME_BITS   = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int SVC_W      = 10;
  localparam int MAXW_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int EV_W       = 2;
  localparam int WAIT_W     = 32;
  localparam int OVF_W      = 2;
  localparam int CNT32_W    = 32;
  localparam int SUM_W      = 48;
  localparam int QLEN_W     = 7;

  localparam int TDATA_W  = WAIT_W + OVF_W + 3 * CNT32_W + 2 * SUM_W + 2 * QLEN_W;
  localparam int TUSER_W  = EV_W;
  localparam int S_TDATA_W = 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [CNT_W-1:0]     fill_t;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_LANDING_SVC = 2'd0;
  localparam cfg_idx_t CFG_TAKEOFF_SVC = 2'd1;
  localparam cfg_idx_t CFG_MAX_WAIT    = 2'd2;

  typedef logic [EV_W-1:0] event_t;
  localparam event_t EV_NONE    = 2'd0;
  localparam event_t EV_LANDING = 2'd1;
  localparam event_t EV_TAKEOFF = 2'd2;
  localparam event_t EV_CRASH   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic push;   // stamp arrivals into the FIFOs
    logic read;   // read both queue heads
    logic exec;   // scheduling decision, state update, result load
  } cmd_t;

  typedef struct packed {
    logic [QLEN_W-1:0]  takeoff_queue_len;
    logic [QLEN_W-1:0]  landing_queue_len;
    logic [SUM_W-1:0]   takeoff_wait_total;
    logic [SUM_W-1:0]   landing_wait_total;
    logic [CNT32_W-1:0] takeoff_count;
    logic [CNT32_W-1:0] landing_count;
    logic [CNT32_W-1:0] crash_count;
    logic [OVF_W-1:0]   overflow;
    logic [WAIT_W-1:0]  wait_ticks;
    event_t             event_res;
  } res_t;

endpackage

// ===== hdl/rprq_ctrl.sv =====
// Sequencer for the runway scheduler: push, head read, execute.
// Depends on rprq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rprq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic          out_free,
  output rprq_pkg::cmd_t cmd
);
  import rprq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // no item is taken while reset is held
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        cmd.push = s_tvalid && !rst;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  `RPRQ_ASSERT_NXT(a_accept_reads, s_tvalid && s_tready, cmd.read)
  `RPRQ_ASSERT_IMP(a_cmd_exclusive, 1'b1, $onehot0({cmd.push, cmd.read, cmd.exec}))
  `RPRQ_ASSERT_NXT(a_stall_holds, (state == ST_EXEC) && !out_free,
                   (state == ST_EXEC) && !s_tready)

endmodule

// ===== hdl/rprq_dp.sv =====
// Datapath of the runway scheduler: config registers, two stamp FIFOs,
// tick and busy timers, saturating statistics. Depends on rprq_pkg.
`include "assert_macros.svh"

module rprq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  rprq_pkg::cfg_idx_t                cfg_index,
  input  logic [rprq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              landing_arrival,
  input  logic                              takeoff_arrival,
  input  rprq_pkg::cmd_t                    cmd,
  output rprq_pkg::res_t                    res
);
  import rprq_pkg::*;

  localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MAX48 = 64'h0000_FFFF_FFFF_FFFF;

  function automatic addr_t ring_tail(input addr_t head, input fill_t fill);
    logic [CNT_W:0] sum;
    begin
      sum = {1'b0, CNT_W'(head)} + {1'b0, fill};
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      return sum[ADDR_W-1:0];
    end
  endfunction

  function automatic addr_t ring_next(input addr_t head);
    return (head == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  endfunction

  function automatic logic [CNT32_W-1:0] sat_inc(input logic [CNT32_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [63:0] w);
    logic [SUM_W:0] sum;
    begin
      sum = {1'b0, s} + {1'b0, w[SUM_W-1:0]};
      return ((w >= MAX48) || sum[SUM_W]) ? '1 : sum[SUM_W-1:0];
    end
  endfunction

  logic [SVC_W-1:0]  landing_svc, takeoff_svc;
  logic [MAXW_W-1:0] max_wait;

  time_t tick_now, busy_until;
  time_t landing_mem [QUEUE_DEPTH];
  time_t takeoff_mem [QUEUE_DEPTH];
  time_t landing_rd, takeoff_rd;
  addr_t landing_head, takeoff_head;
  fill_t landing_fill, takeoff_fill;
  logic [OVF_W-1:0]   ovf;
  logic [CNT32_W-1:0] crashes, landings_done, takeoffs_done;
  logic [SUM_W-1:0]   landing_wsum, takeoff_wsum;

  logic  landing_ok, takeoff_ok, landing_full, takeoff_full;
  time_t remain, landing_wait, takeoff_wait;
  logic  server_free, landing_pop, takeoff_pop, crash;
  logic [63:0] landing_w64, takeoff_w64, sel_w64;
  time_t busy_until_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      landing_svc <= SVC_W'(5);
      takeoff_svc <= SVC_W'(5);
      max_wait    <= MAXW_W'(20);
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_LANDING_SVC: landing_svc <= cfg_data[SVC_W-1:0];
        CFG_TAKEOFF_SVC: takeoff_svc <= cfg_data[SVC_W-1:0];
        CFG_MAX_WAIT:    max_wait    <= cfg_data[MAXW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign landing_full = (landing_fill == CNT_W'(QUEUE_DEPTH));
  assign takeoff_full = (takeoff_fill == CNT_W'(QUEUE_DEPTH));
  assign landing_ok   = cmd.push && landing_arrival && !landing_full;
  assign takeoff_ok   = cmd.push && takeoff_arrival && !takeoff_full;

  // stamp stores
  always_ff @(posedge clk) begin
    if (landing_ok) landing_mem[ring_tail(landing_head, landing_fill)] <= tick_now;
    if (takeoff_ok) takeoff_mem[ring_tail(takeoff_head, takeoff_fill)] <= tick_now;
    if (cmd.read) begin
      landing_rd <= landing_mem[landing_head];
      takeoff_rd <= takeoff_mem[takeoff_head];
    end
  end

  // scheduling decision, evaluated from registered state in the exec cycle
  always_comb begin
    remain       = busy_until - tick_now;
    server_free  = (remain == '0) || remain[TIME_BITS-1];
    landing_pop  = server_free && (landing_fill != '0);
    takeoff_pop  = server_free && !landing_pop && (takeoff_fill != '0);
    landing_wait = tick_now - landing_rd;
    takeoff_wait = tick_now - takeoff_rd;
    landing_w64  = 64'(landing_wait);
    takeoff_w64  = 64'(takeoff_wait);
    crash        = landing_pop && (landing_w64 > 64'(max_wait));
    sel_w64      = landing_pop ? landing_w64 : (takeoff_pop ? takeoff_w64 : '0);

    busy_until_next = busy_until;
    if (server_free) begin
      busy_until_next = tick_now;
      if (landing_pop && !crash) begin
        busy_until_next = tick_now + TIME_BITS'(landing_svc);
      end else if (takeoff_pop) begin
        busy_until_next = tick_now + TIME_BITS'(takeoff_svc);
      end
    end

    res.event_res = crash ? EV_CRASH : landing_pop ? EV_LANDING :
                    takeoff_pop ? EV_TAKEOFF : EV_NONE;
    res.wait_ticks = (sel_w64 > MAX32) ? '1 : sel_w64[WAIT_W-1:0];
    res.overflow   = ovf;
    res.crash_count   = crash ? sat_inc(crashes) : crashes;
    res.landing_count = (landing_pop && !crash) ? sat_inc(landings_done) : landings_done;
    res.takeoff_count = takeoff_pop ? sat_inc(takeoffs_done) : takeoffs_done;
    res.landing_wait_total = (landing_pop && !crash) ?
                             sat_add(landing_wsum, landing_w64) : landing_wsum;
    res.takeoff_wait_total = takeoff_pop ? sat_add(takeoff_wsum, takeoff_w64) : takeoff_wsum;
    res.landing_queue_len  = QLEN_W'(landing_fill - CNT_W'(landing_pop));
    res.takeoff_queue_len  = QLEN_W'(takeoff_fill - CNT_W'(takeoff_pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now      <= '0;
      busy_until    <= '0;
      landing_head  <= '0;
      takeoff_head  <= '0;
      landing_fill  <= '0;
      takeoff_fill  <= '0;
      ovf           <= '0;
      crashes       <= '0;
      landings_done <= '0;
      takeoffs_done <= '0;
      landing_wsum  <= '0;
      takeoff_wsum  <= '0;
    end else if (cmd.push) begin
      landing_fill <= landing_fill + CNT_W'(landing_ok);
      takeoff_fill <= takeoff_fill + CNT_W'(takeoff_ok);
      ovf          <= {takeoff_arrival && takeoff_full, landing_arrival && landing_full};
    end else if (cmd.exec) begin
      tick_now      <= tick_now + 1'b1;
      busy_until    <= busy_until_next;
      landing_fill  <= landing_fill - CNT_W'(landing_pop);
      takeoff_fill  <= takeoff_fill - CNT_W'(takeoff_pop);
      if (landing_pop) landing_head <= ring_next(landing_head);
      if (takeoff_pop) takeoff_head <= ring_next(takeoff_head);
      crashes       <= res.crash_count;
      landings_done <= res.landing_count;
      takeoffs_done <= res.takeoff_count;
      landing_wsum  <= res.landing_wait_total;
      takeoff_wsum  <= res.takeoff_wait_total;
    end
  end

  `RPRQ_ASSERT_IMP(a_landing_fill_max, 1'b1, landing_fill <= CNT_W'(QUEUE_DEPTH))
  `RPRQ_ASSERT_IMP(a_takeoff_fill_max, 1'b1, takeoff_fill <= CNT_W'(QUEUE_DEPTH))
  `RPRQ_ASSERT_NXT(a_busy_only_on_exec, !cmd.exec, $stable(busy_until) && $stable(tick_now))

endmodule

// ===== hdl/runway_priority_queue_scheduler.sv =====
// Runway priority queue scheduler: one input item is one simulation tick.
//
// Input channel s_*: tdata[0] landing arrival, tdata[1] takeoff arrival.
// Output channel m_*: one result item per tick; tuser carries the event code
// (none, landing served, takeoff served, landing dropped), tdata carries the
// wait, push-overflow flags, saturating totals and both queue lengths.
// Config port: cfg_wen/cfg_index/cfg_data writes landing service time (0),
// takeoff service time (1) and max landing wait (2); write only when idle.
//
// Each item passes these steps in order: push into the stamp FIFOs, a
// registered read of both FIFO heads from their memories, then the
// scheduling step that loads the output register. No new item is taken
// before that step; the next one can be taken in the following cycle.
// The output register lets the next item be taken while a result waits; if
// the receiver still stalls, the block holds in its last step and s_tready
// stays low. Synchronous reset clears queues, timers, totals and the output
// valid, and loads the register defaults (5, 5, 20). No clearing pass.
// Depends on rprq_pkg, rprq_ctrl and rprq_dp.

module runway_priority_queue_scheduler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bit 0 landing_arrival, bit 1 takeoff_arrival, rest zero
  input  logic [rprq_pkg::S_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // from bit 0: wait_ticks, overflow, crash_count, landing_count,
  // takeoff_count, landing_wait_total, takeoff_wait_total,
  // landing_queue_len, takeoff_queue_len
  output logic [rprq_pkg::TDATA_W-1:0]      m_tdata,
  // event_res
  output logic [rprq_pkg::TUSER_W-1:0]      m_tuser,
  input  logic                              cfg_wen,
  input  rprq_pkg::cfg_idx_t                cfg_index,
  input  logic [rprq_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rprq_pkg::*;

  cmd_t cmd;
  res_t res, res_q;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;

  rprq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  rprq_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wen         (cfg_wen),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .landing_arrival (s_tdata[0]),
    .takeoff_arrival (s_tdata[1]),
    .cmd             (cmd),
    .res             (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) res_q <= res;
  end

  assign m_tuser = res_q.event_res;
  assign m_tdata = {res_q.takeoff_queue_len, res_q.landing_queue_len,
                    res_q.takeoff_wait_total, res_q.landing_wait_total,
                    res_q.takeoff_count, res_q.landing_count, res_q.crash_count,
                    res_q.overflow, res_q.wait_ticks};

endmodule
